FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: the job record
// passed from the front end to the output sequencer, and UTF-8 limits.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // code point limits for the utf-8 length classes
    localparam logic [20:0] CP_LIM1 = 21'h00080;
    localparam logic [20:0] CP_LIM2 = 21'h00800;
    localparam logic [20:0] CP_LIM3 = 21'h10000;

    // utf-8 lead and continuation markers
    localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3 = 8'he0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [5:0] UTF8_MASK  = 6'h3f;

    // surrogate ranges
    localparam logic [15:0] SURR_HIGH = 16'hd800;
    localparam logic [15:0] SURR_LOW  = 16'hdc00;
    localparam logic [15:0] SURR_END  = 16'he000;

    // everything one accepted item produces, in output order:
    // code point a, held hex digits, code point b, literal byte, end marker
    typedef struct packed {
        logic            cpa_en;
        logic [20:0]     cpa;
        logic [1:0]      held_n;
        logic [2:0][7:0] held;
        logic            cpb_en;
        logic [15:0]     cpb;
        logic            lit_en;
        logic [7:0]      lit;
        logic            mark_en;
        logic            mark_ns;
    } t_job;

endpackage

FILE: rtl/jsu_ifs.sv
// ----------------------------------------------------------------------------
// jsu channel interfaces
// Valid/ready channels for input bytes and for decoded result items.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       value_start;
    logic       span_end;

    modport source (output valid, in_byte, value_start, span_end, input ready);
    modport sink   (input valid, in_byte, value_start, span_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       not_string;

    modport source (output valid, out_byte, byte_valid, run_last, string_done, not_string,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, run_last, string_done, not_string,
                    output ready);
endinterface

FILE: rtl/json_string_unescape_utf8.sv
// first result of an input item: queue slot, then job register, then output register
// throughput: one input item per cycle while the queue is not full, and one result
//   item per cycle unless stalled; the sequencer emits 0 to 8 results per input
// the job queue (QUEUE_DEPTH entries) decouples input acceptance from output stalls
// reset (synchronous, active low) empties the queue and returns to idle awaiting a value
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a JSON string span into UTF-8 bytes with an end marker per value.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    logic          push, full, job_valid, pop;
    jsu_pkg::t_job front_job, head_job;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (job_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts one byte per cycle while the job queue is not full, runs the
// string/escape state machine and turns each item into a job record describing the bytes it produces.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jsu_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output jsu_pkg::t_job  o_job
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_LEAD     = 4'd1;
    localparam logic [3:0] PH_BODY     = 4'd2;
    localparam logic [3:0] PH_ESC      = 4'd3;
    localparam logic [3:0] PH_HEX      = 4'd4;
    localparam logic [3:0] PH_PAIR_BS  = 4'd5;
    localparam logic [3:0] PH_PAIR_U   = 4'd6;
    localparam logic [3:0] PH_PAIR_HEX = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [1:0] DIGITS_HELD = 2'd3;

    logic [3:0]      r_phase, n_phase;
    logic [15:0]     r_cu, n_cu;
    logic [15:0]     r_hh, n_hh;
    logic [1:0]      r_dc, n_dc;
    logic [2:0][7:0] r_held, n_held;

    logic [3:0]      ph0;
    logic [15:0]     cu0, hh0, cu_shift;
    logic [1:0]      dc0;
    logic            hex_ok;
    logic [3:0]      hex_nib;
    logic            body_go, esc_go, unit_go;
    logic            accept;
    logic [7:0]      c;
    jsu_pkg::t_job   job;

    assign c      = i_in.in_byte;
    assign i_in.ready = !i_full;
    assign accept = i_in.valid && !i_full;

    always_comb begin
        hex_ok  = 1'b1;
        hex_nib = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_nib = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_nib = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        ph0 = r_phase;
        cu0 = r_cu;
        hh0 = r_hh;
        dc0 = r_dc;
        if (i_in.value_start) begin
            ph0 = PH_LEAD;
            cu0 = '0;
            hh0 = '0;
            dc0 = '0;
        end
        n_phase  = ph0;
        n_cu     = cu0;
        n_hh     = hh0;
        n_dc     = dc0;
        n_held   = r_held;
        job      = '0;
        body_go  = 1'b0;
        esc_go   = 1'b0;
        unit_go  = 1'b0;
        cu_shift = {cu0[11:0], hex_nib};

        case (ph0)
            PH_LEAD: begin
                if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF) begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_BODY;
                    end else begin
                        job.mark_en = 1'b1;
                        job.mark_ns = 1'b1;
                        n_phase     = PH_DONE;
                    end
                end
            end
            PH_BODY: body_go = 1'b1;
            PH_ESC:  esc_go  = 1'b1;
            PH_HEX, PH_PAIR_HEX: begin
                if (!hex_ok) begin
                    // bad digit: pending high half, then digits taken literally
                    if (ph0 == PH_PAIR_HEX) begin
                        job.cpa_en = 1'b1;
                        job.cpa    = {5'd0, hh0};
                    end
                    job.held_n = dc0;
                    n_dc       = '0;
                    body_go    = 1'b1;
                end else begin
                    n_cu = cu_shift;
                    if (dc0 != DIGITS_HELD) begin
                        n_held[dc0] = c;
                        n_dc        = dc0 + 2'd1;
                    end else begin
                        n_dc = '0;
                        if (ph0 == PH_HEX) begin
                            unit_go = 1'b1;
                        end else if (cu_shift >= jsu_pkg::SURR_LOW &&
                                     cu_shift <  jsu_pkg::SURR_END) begin
                            job.cpa_en = 1'b1;
                            job.cpa    = jsu_pkg::CP_LIM3 + {1'b0, hh0[9:0], cu_shift[9:0]};
                            n_phase    = PH_BODY;
                        end else begin
                            job.cpa_en = 1'b1;
                            job.cpa    = {5'd0, hh0};
                            unit_go    = 1'b1;
                        end
                    end
                end
            end
            PH_PAIR_BS: begin
                if (c == CH_BSLASH) begin
                    n_phase = PH_PAIR_U;
                end else begin
                    job.cpa_en = 1'b1;
                    job.cpa    = {5'd0, hh0};
                    body_go    = 1'b1;
                end
            end
            PH_PAIR_U: begin
                if (c == CH_U) begin
                    n_phase = PH_PAIR_HEX;
                    n_dc    = '0;
                    n_cu    = '0;
                end else begin
                    job.cpa_en = 1'b1;
                    job.cpa    = {5'd0, hh0};
                    esc_go     = 1'b1;
                end
            end
            default: ;
        endcase

        if (unit_go) begin
            if (cu_shift >= jsu_pkg::SURR_HIGH && cu_shift < jsu_pkg::SURR_LOW) begin
                n_hh    = cu_shift;
                n_phase = PH_PAIR_BS;
            end else begin
                job.cpb_en = 1'b1;
                job.cpb    = cu_shift;
                n_phase    = PH_BODY;
            end
        end

        if (body_go) begin
            n_phase = PH_BODY;
            case (c)
                CH_QUOTE: begin
                    job.mark_en = 1'b1;
                    n_phase     = PH_DONE;
                end
                CH_BSLASH: n_phase = PH_ESC;
                default: begin
                    job.lit_en = 1'b1;
                    job.lit    = c;
                end
            endcase
        end

        if (esc_go) begin
            n_phase    = PH_BODY;
            job.lit_en = 1'b1;
            case (c)
                CH_N:    job.lit = CH_LF;
                CH_T:    job.lit = CH_TAB;
                CH_R:    job.lit = CH_CR;
                CH_B:    job.lit = CH_BS;
                CH_F:    job.lit = CH_FF;
                CH_U: begin
                    job.lit_en = 1'b0;
                    n_phase    = PH_HEX;
                    n_dc       = '0;
                    n_cu       = '0;
                end
                default: job.lit = c;
            endcase
        end

        // end of span: flush what is still pending, then the end marker
        if (i_in.span_end) begin
            case (n_phase)
                PH_LEAD: begin
                    job.mark_en = 1'b1;
                    job.mark_ns = 1'b1;
                    n_phase     = PH_DONE;
                end
                PH_BODY, PH_ESC: begin
                    job.mark_en = 1'b1;
                    n_phase     = PH_DONE;
                end
                PH_HEX: begin
                    job.held_n  = n_dc;
                    n_dc        = '0;
                    job.mark_en = 1'b1;
                    n_phase     = PH_DONE;
                end
                PH_PAIR_BS, PH_PAIR_U: begin
                    job.cpb_en  = 1'b1;
                    job.cpb     = n_hh;
                    job.mark_en = 1'b1;
                    n_phase     = PH_DONE;
                end
                PH_PAIR_HEX: begin
                    job.cpa_en  = 1'b1;
                    job.cpa     = {5'd0, n_hh};
                    job.held_n  = n_dc;
                    n_dc        = '0;
                    job.mark_en = 1'b1;
                    n_phase     = PH_DONE;
                end
                default: ;
            endcase
        end

        job.held = n_held;
    end

    assign o_job  = job;
    assign o_push = accept && (job.cpa_en || job.held_n != 2'd0 || job.cpb_en ||
                               job.lit_en || job.mark_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cu    <= '0;
            r_hh    <= '0;
            r_dc    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cu    <= n_cu;
            r_hh    <= n_hh;
            r_dc    <= n_dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

FILE: rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Small job queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsu_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output jsu_pkg::t_job  o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    jsu_pkg::t_job r_slot [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: takes one job at a time and encodes its code points as
// UTF-8; a registered output gives one result item per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  jsu_pkg::t_job  i_job,
    output logic           o_pop,
    jsu_out_if.source      o_out
);

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < jsu_pkg::CP_LIM1)      n = 3'd1;
        else if (cp < jsu_pkg::CP_LIM2) n = 3'd2;
        else if (cp < jsu_pkg::CP_LIM3) n = 3'd3;
        else                            n = 3'd4;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
        logic [2:0] n;
        logic [7:0] b;
        n = utf8_len(cp);
        b = cp[7:0];
        case (n)
            3'd2: b = (k == 2'd0) ? (jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]})
                                  : (jsu_pkg::UTF8_CONT | {2'd0, cp[5:0] & jsu_pkg::UTF8_MASK});
            3'd3: begin
                case (k)
                    2'd0:    b = jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
                    2'd1:    b = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
                    default: b = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    2'd0:    b = jsu_pkg::UTF8_LEAD4 | {5'd0, cp[20:18]};
                    2'd1:    b = jsu_pkg::UTF8_CONT | {2'd0, cp[17:12]};
                    2'd2:    b = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
                    default: b = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

    jsu_pkg::t_job r_job;
    logic          r_busy;
    logic [2:0]    r_pos;
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_bv, r_last, r_done, r_ns;

    logic [20:0]   cpb_w;
    logic [3:0]    len_a, len_b, b1, b2, b3, b4, total, pos4, k;
    logic [7:0]    sel_byte;
    logic          sel_bv, sel_done, sel_ns, sel_last;
    logic          out_take, advance;

    assign cpb_w = {5'd0, r_job.cpb};
    assign len_a = r_job.cpa_en ? {1'b0, utf8_len(r_job.cpa)} : 4'd0;
    assign len_b = r_job.cpb_en ? {1'b0, utf8_len(cpb_w)} : 4'd0;
    assign b1    = len_a;
    assign b2    = b1 + {2'd0, r_job.held_n};
    assign b3    = b2 + len_b;
    assign b4    = b3 + {3'd0, r_job.lit_en};
    assign total = b4 + {3'd0, r_job.mark_en};
    assign pos4  = {1'b0, r_pos};

    // locate the segment that the current position falls into
    always_comb begin
        sel_bv   = 1'b1;
        sel_done = 1'b0;
        sel_ns   = 1'b0;
        k        = '0;
        if (pos4 < b1) begin
            sel_byte = utf8_byte(r_job.cpa, r_pos[1:0]);
        end else if (pos4 < b2) begin
            k = pos4 - b1;
            case (k[1:0])
                2'd1:    sel_byte = r_job.held[1];
                2'd2:    sel_byte = r_job.held[2];
                default: sel_byte = r_job.held[0];
            endcase
        end else if (pos4 < b3) begin
            k        = pos4 - b2;
            sel_byte = utf8_byte(cpb_w, k[1:0]);
        end else if (pos4 < b4) begin
            sel_byte = r_job.lit;
        end else begin
            sel_byte = 8'd0;
            sel_bv   = 1'b0;
            sel_done = 1'b1;
            sel_ns   = r_job.mark_ns;
        end
    end

    assign sel_last = (pos4 + 4'd1 == total);
    assign out_take = !r_ov || o_out.ready;
    assign advance  = r_busy && out_take;
    assign o_pop    = i_job_valid && (!r_busy || (advance && sel_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (out_take) begin
                r_ov <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (advance) begin
                if (sel_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (advance) begin
            r_byte <= sel_byte;
            r_bv   <= sel_bv;
            r_last <= sel_last;
            r_done <= sel_done;
            r_ns   <= sel_ns;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_byte;
    assign o_out.byte_valid  = r_bv;
    assign o_out.run_last    = r_last;
    assign o_out.string_done = r_done;
    assign o_out.not_string  = r_ns;

endmodule

FILE: rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the string unescaper.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_run_last,
    input logic       i_string_done,
    input logic       i_not_string
);

    // a stalled item holds its byte and its byte_valid and string_done flags
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
            $stable(i_byte_valid) && $stable(i_string_done))
        else $error("result item changed while stalled");

    // the end marker carries no byte and closes its input's run
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_done |-> !i_byte_valid && i_run_last)
        else $error("end marker malformed");

    // every item is either a byte or an end marker
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_string_done && i_out_byte == 8'd0)
        else $error("result item is neither byte nor marker");

    // not_string only appears on an end marker
    a_ns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_not_string |-> i_string_done)
        else $error("not_string outside end marker");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_run_last    (o_out.run_last),
    .i_string_done (o_out.string_done),
    .i_not_string  (o_out.not_string)
);

FILE: test/jsu_tb_pkg.sv
// ----------------------------------------------------------------------------
// jsu_tb_pkg
// Character codes shared by the stimulus and the decode check of the JSON
// string unescaper testbench.
// ----------------------------------------------------------------------------
package jsu_tb_pkg;

    // structural characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    // whitespace and control bytes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BKSP  = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0c;

    // escape letters
    localparam logic [7:0] LET_N = 8'h6e;
    localparam logic [7:0] LET_T = 8'h74;
    localparam logic [7:0] LET_R = 8'h72;
    localparam logic [7:0] LET_B = 8'h62;
    localparam logic [7:0] LET_F = 8'h66;
    localparam logic [7:0] LET_U = 8'h75;

    // hex digit ranges
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

endpackage

FILE: test/jsu_decode_check.sv
// ----------------------------------------------------------------------------
// jsu_decode_check
// Watches both channels of the unescaper, decodes every accepted input item
// into the UTF-8 result items it should cause, and compares each accepted
// result item field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module jsu_decode_check (
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if    i_in_mon,
    jsu_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_string_count,
    output int   o_not_string_count
);
    import jsu_pkg::*;
    import jsu_tb_pkg::*;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_PAIR_BSL,
        SCAN_PAIR_U,
        SCAN_PAIR_HEX,
        SCAN_DONE
    } t_scan;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
        logic       not_string;
    } t_utf8_item;

    t_scan       scan = SCAN_IDLE;
    logic [15:0] unit_acc = '0;
    logic [15:0] high_half_q = '0;
    logic [2:0]  digit_n = '0;
    logic [7:0]  digit_buf [3];
    t_utf8_item  step_items [$];
    t_utf8_item  utf8_expected [$];
    t_utf8_item  next_want;
    int          fail_n = 0;
    int          result_n = 0;
    int          string_n = 0;
    int          ns_n = 0;

    assign o_fail_count       = fail_n;
    assign o_result_count     = result_n;
    assign o_string_count     = string_n;
    assign o_not_string_count = ns_n;

    task automatic store_item(input t_utf8_item r);
        // a single input item never causes more than eight result items
        if (step_items.size() < MAX_RESULTS) begin
            step_items.push_back(r);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        t_utf8_item r;
        r = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, string_done: 1'b0,
              not_string: 1'b0};
        store_item(r);
    endtask

    task automatic close_value(input logic ns);
        t_utf8_item r;
        r = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0, string_done: 1'b1,
              not_string: ns};
        store_item(r);
        scan = SCAN_DONE;
    endtask

    task automatic put_code_point(input logic [20:0] u);
        if (u < CP_LIM1) begin
            put_byte(u[7:0]);
        end else if (u < CP_LIM2) begin
            put_byte(UTF8_LEAD2 | {3'd0, u[10:6]});
            put_byte(UTF8_CONT | {2'd0, u[5:0]});
        end else if (u < CP_LIM3) begin
            put_byte(UTF8_LEAD3 | {4'd0, u[15:12]});
            put_byte(UTF8_CONT | {2'd0, u[11:6]});
            put_byte(UTF8_CONT | {2'd0, u[5:0]});
        end else begin
            put_byte(UTF8_LEAD4 | {5'd0, u[20:18]});
            put_byte(UTF8_CONT | {2'd0, u[17:12]});
            put_byte(UTF8_CONT | {2'd0, u[11:6]});
            put_byte(UTF8_CONT | {2'd0, u[5:0]});
        end
    endtask

    task automatic flush_digits();
        int i;
        for (i = 0; i < int'(digit_n) && i < 3; i++) begin
            put_byte(digit_buf[i]);
        end
        digit_n = '0;
    endtask

    task automatic body_char(input logic [7:0] c);
        scan = SCAN_BODY;
        if (c == CH_QUOTE) begin
            close_value(1'b0);
        end else if (c == CH_BSL) begin
            scan = SCAN_ESC;
        end else begin
            put_byte(c);
        end
    endtask

    task automatic escape_char(input logic [7:0] c);
        scan = SCAN_BODY;
        case (c)
            LET_N: put_byte(CH_LF);
            LET_T: put_byte(CH_TAB);
            LET_R: put_byte(CH_CR);
            LET_B: put_byte(CH_BKSP);
            LET_F: put_byte(CH_FF);
            LET_U: begin
                scan     = SCAN_HEX;
                digit_n  = '0;
                unit_acc = '0;
            end
            default: put_byte(c);
        endcase
    endtask

    // a decoded unit that does not join a waiting high half
    task automatic take_unit(input logic [15:0] u);
        if (u >= SURR_HIGH && u < SURR_LOW) begin
            high_half_q = u;
            scan        = SCAN_PAIR_BSL;
        end else begin
            put_code_point({5'd0, u});
            scan = SCAN_BODY;
        end
    endtask

    task automatic unescape_byte(input logic [7:0] c, input logic vs, input logic se);
        logic [4:0] nib;
        step_items.delete();
        if (vs) begin
            scan        = SCAN_LEAD;
            unit_acc    = '0;
            high_half_q = '0;
            digit_n     = '0;
        end
        case (scan)
            SCAN_LEAD: begin
                if (c == CH_QUOTE) begin
                    scan = SCAN_BODY;
                end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF) begin
                    close_value(1'b1);
                end
            end
            SCAN_BODY: body_char(c);
            SCAN_ESC:  escape_char(c);
            SCAN_HEX, SCAN_PAIR_HEX: begin
                if (c >= CH_0 && c <= CH_9) begin
                    nib = {1'b0, 4'(c - CH_0)};
                end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
                    nib = {1'b0, 4'(c - CH_LOW_A + 8'd10)};
                end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                    nib = {1'b0, 4'(c - CH_UP_A + 8'd10)};
                end else begin
                    nib = 5'h10;
                end
                if (nib[4]) begin
                    // bad digit: a pending high half goes out first, held digits go out as text, the byte is body text
                    if (scan == SCAN_PAIR_HEX) put_code_point({5'd0, high_half_q});
                    flush_digits();
                    body_char(c);
                end else begin
                    unit_acc = {unit_acc[11:0], nib[3:0]};
                    if (digit_n < 3'd3) begin
                        digit_buf[digit_n] = c;
                        digit_n++;
                    end else begin
                        digit_n = '0;
                        if (scan == SCAN_HEX) begin
                            take_unit(unit_acc);
                        end else if (unit_acc >= SURR_LOW && unit_acc < SURR_END) begin
                            put_code_point(CP_LIM3 + {1'b0, high_half_q[9:0], unit_acc[9:0]});
                            scan = SCAN_BODY;
                        end else begin
                            put_code_point({5'd0, high_half_q});
                            take_unit(unit_acc);
                        end
                    end
                end
            end
            SCAN_PAIR_BSL: begin
                if (c == CH_BSL) begin
                    scan = SCAN_PAIR_U;
                end else begin
                    put_code_point({5'd0, high_half_q});
                    body_char(c);
                end
            end
            SCAN_PAIR_U: begin
                if (c == LET_U) begin
                    scan     = SCAN_PAIR_HEX;
                    digit_n  = '0;
                    unit_acc = '0;
                end else begin
                    put_code_point({5'd0, high_half_q});
                    escape_char(c);
                end
            end
            default: ;
        endcase
        if (se) begin
            case (scan)
                SCAN_LEAD: close_value(1'b1);
                SCAN_BODY, SCAN_ESC: close_value(1'b0);
                SCAN_HEX: begin
                    flush_digits();
                    close_value(1'b0);
                end
                SCAN_PAIR_BSL, SCAN_PAIR_U: begin
                    put_code_point({5'd0, high_half_q});
                    close_value(1'b0);
                end
                SCAN_PAIR_HEX: begin
                    put_code_point({5'd0, high_half_q});
                    flush_digits();
                    close_value(1'b0);
                end
                default: ;
            endcase
        end
        if (step_items.size() > 0) begin
            step_items[step_items.size() - 1].run_last = 1'b1;
        end
        foreach (step_items[k]) utf8_expected.push_back(step_items[k]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_n++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan        = SCAN_IDLE;
            unit_acc    = '0;
            high_half_q = '0;
            digit_n     = '0;
            utf8_expected.delete();
        end else begin
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                unescape_byte(i_in_mon.in_byte, i_in_mon.value_start, i_in_mon.span_end);
            end
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                result_n++;
                if (i_out_mon.string_done === 1'b1) string_n++;
                if (i_out_mon.not_string === 1'b1) ns_n++;
                if (utf8_expected.size() == 0) begin
                    $error("result item with nothing outstanding: out_byte 0x%0h done %0b",
                           i_out_mon.out_byte, i_out_mon.string_done);
                    fail_n++;
                end else begin
                    next_want = utf8_expected.pop_front();
                    check_field("out_byte", next_want.out_byte, i_out_mon.out_byte);
                    check_field("byte_valid", {7'd0, next_want.byte_valid},
                                {7'd0, i_out_mon.byte_valid});
                    check_field("run_last", {7'd0, next_want.run_last},
                                {7'd0, i_out_mon.run_last});
                    check_field("string_done", {7'd0, next_want.string_done},
                                {7'd0, i_out_mon.string_done});
                    check_field("not_string", {7'd0, next_want.not_string},
                                {7'd0, i_out_mon.not_string});
                end
            end
        end
        o_pending <= utf8_expected.size();
    end

endmodule

FILE: test/tb_json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Drives JSON value spans into the unescaper: a few hand-picked spans, then
// random strings with escapes, surrogate pairs and broken endings, under
// bursty input and a stalling receiver. The decode check does the scoring.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;
    import jsu_tb_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [15:0] UNIT_LIMITS [12] = '{
        16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hd7ff,
        16'hd800, 16'hdbff, 16'hdc00, 16'hdfff, 16'he000, 16'hffff
    };

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SPARSE} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic [7:0] span_q [$];
    int         burst_left = 0;
    int         items_sent = 0;
    int         values_sent = 0;
    int         cycle_n = 0;
    bit         hold_req = 1'b0;
    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_left = 0;

    int fail_count;
    int pending_count;
    int result_count;
    int string_count;
    int ns_count;

    jsu_in_if  byte_ch ();
    jsu_out_if utf8_ch ();

    json_string_unescape_utf8 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (utf8_ch)
    );

    jsu_decode_check u_decode_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_mon           (byte_ch),
        .i_out_mon          (utf8_ch),
        .o_fail_count       (fail_count),
        .o_pending          (pending_count),
        .o_result_count     (result_count),
        .o_string_count     (string_count),
        .o_not_string_count (ns_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d result items outstanding",
                     cycle_n, pending_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: its own stall pattern, plus one long hold on request
    initial begin
        utf8_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                utf8_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    case ($urandom_range(0, 3))
                        0, 1:    rx_mode = RX_OPEN;
                        2:       rx_mode = RX_CHOPPY;
                        default: rx_mode = RX_SPARSE;
                    endcase
                    rx_left = $urandom_range(8, 60);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   utf8_ch.ready <= 1'b1;
                    RX_CHOPPY: utf8_ch.ready <= 1'($urandom_range(0, 1));
                    default:   utf8_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // called and returns at a falling edge; valid stays high into the next item
    task automatic send_item(input logic [7:0] b, input logic vs, input logic se);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        byte_ch.valid       <= 1'b1;
        byte_ch.in_byte     <= b;
        byte_ch.value_start <= vs;
        byte_ch.span_end    <= se;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_span(input bit close);
        int i;
        for (i = 0; i < span_q.size(); i++) begin
            send_item(span_q[i], i == 0, close && (i == span_q.size() - 1));
        end
        values_sent++;
        span_q.delete();
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge i_clk);
        // items that cause nothing may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) span_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + {4'd0, n};
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic add_unit(input logic [15:0] u);
        span_q.push_back(CH_BSL);
        span_q.push_back(LET_U);
        span_q.push_back(hex_digit(u[15:12]));
        span_q.push_back(hex_digit(u[11:8]));
        span_q.push_back(hex_digit(u[7:4]));
        span_q.push_back(hex_digit(u[3:0]));
    endtask

    task automatic add_random_token();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
            span_q.push_back(b);
        end else if (r < 55) begin
            span_q.push_back(CH_BSL);
            case ($urandom_range(0, 8))
                0:       span_q.push_back(LET_N);
                1:       span_q.push_back(LET_T);
                2:       span_q.push_back(LET_R);
                3:       span_q.push_back(LET_B);
                4:       span_q.push_back(LET_F);
                5:       span_q.push_back(CH_QUOTE);
                6:       span_q.push_back(CH_BSL);
                7:       span_q.push_back(CH_SLASH);
                default: span_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (r < 90) begin
            case ($urandom_range(0, 8))
                0: add_unit(16'($urandom_range(16'h0000, 16'h007f)));
                1: add_unit(16'($urandom_range(16'h0080, 16'h07ff)));
                2: add_unit(16'($urandom_range(16'h0800, SURR_HIGH - 1)));
                3: add_unit(16'($urandom_range(SURR_END, 16'hffff)));
                4: begin
                    add_unit(16'($urandom_range(SURR_HIGH, SURR_LOW - 1)));
                    add_unit(16'($urandom_range(SURR_LOW, SURR_END - 1)));
                end
                5: add_unit(16'($urandom_range(SURR_HIGH, SURR_LOW - 1)));
                6: add_unit(16'($urandom_range(SURR_LOW, SURR_END - 1)));
                7: add_unit(UNIT_LIMITS[$urandom_range(0, 11)]);
                default: begin
                    // lowest and highest supplementary code points
                    if ($urandom_range(0, 1)) begin
                        add_unit(SURR_HIGH);
                        add_unit(SURR_LOW);
                    end else begin
                        add_unit(SURR_LOW - 16'd1);
                        add_unit(SURR_END - 16'd1);
                    end
                end
            endcase
        end else begin
            // broken hex escape, sometimes right after a high half
            if ($urandom_range(0, 2) == 0) begin
                add_unit(16'($urandom_range(SURR_HIGH, SURR_LOW - 1)));
            end
            span_q.push_back(CH_BSL);
            span_q.push_back(LET_U);
            repeat ($urandom_range(0, 3)) span_q.push_back(hex_digit(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255));
            while ((b >= CH_0 && b <= CH_9) || (b >= CH_LOW_A && b <= CH_LOW_F) ||
                   (b >= CH_UP_A && b <= CH_UP_F));
            span_q.push_back(b);
        end
    endtask

    initial begin
        int         base;
        int         mode;
        int         cut;
        bit         hold_started;
        bit         paused;
        logic [7:0] b;

        hold_started        = 1'b0;
        paused              = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.in_byte     = 8'h00;
        byte_ch.value_start = 1'b0;
        byte_ch.span_end    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle: a span end without a value start is ignored
        send_item(8'hff, 1'b0, 1'b1);
        // leading whitespace, extreme bytes, simple and copied escapes, closing quote
        put_text(" \t\"");
        span_q.push_back(8'hff);
        span_q.push_back(8'h00);
        put_text("\\n\\q\"");
        send_span(1'b0);
        // not a string, and span end while still in whitespace
        put_text("{");
        send_span(1'b1);
        put_text(" ");
        send_span(1'b1);
        // surrogate pair to a four byte sequence, span end in the body
        put_text("\"\\ud83d\\uDE00");
        send_span(1'b1);
        // bad hex digit after one held digit
        put_text("\"\\u4g");
        send_span(1'b1);

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS) begin
            if (!hold_started && items_sent >= base + 90) begin
                hold_req     = 1'b1;
                hold_started = 1'b1;
            end
            if (!paused && items_sent >= base + 190) begin
                drain_results();
                paused = 1'b1;
            end
            mode = $urandom_range(0, 99);
            if (mode < 82) begin
                repeat ($urandom_range(0, 2)) span_q.push_back(pick_ws());
                span_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6)) add_random_token();
                span_q.push_back(CH_QUOTE);
                if (mode < 62) begin
                    if ($urandom_range(0, 1)) begin
                        send_span(1'b1);
                    end else begin
                        send_span(1'b0);
                        // trailing byte after the closing quote is ignored
                        if ($urandom_range(0, 1)) send_item(CH_SPACE, 1'b0, 1'b1);
                    end
                end else begin
                    cut = $urandom_range(1, span_q.size() - 1);
                    while (span_q.size() > cut) void'(span_q.pop_back());
                    // truncated by span end, or abandoned by the next value start
                    send_span(mode < 74);
                end
            end else if (mode < 90) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) span_q.push_back(pick_ws());
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB ||
                           b == CH_CR || b == CH_LF);
                    span_q.push_back(b);
                    repeat ($urandom_range(0, 3)) span_q.push_back(8'($urandom_range(0, 255)));
                end
                send_span(1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                end
            end
        end

        drain_results();
        $display("covered %0d input items over %0d values, with a long receiver hold",
                 items_sent, values_sent);
        $display("and a full drain midway; %0d result items, %0d values ended, %0d not strings",
                 result_count, string_count, ns_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
